### rtl/core/software_timer_bank_assert.svh
// assertion macros shared by the timer bank rtl
`ifndef SOFTWARE_TIMER_BANK_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STB_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("timer bank check failed");

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("timer bank check failed");

`else

`define STB_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define STB_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

### rtl/core/stb_pkg.sv
package stb_pkg;

    // fixed field widths
    localparam int IDX_W    = 5;
    localparam int PERIOD_W = 16;

    // command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [IDX_W-1:0]    timer_index;
        logic [PERIOD_W-1:0] period_ticks;
        logic                periodic;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] expired_index;
        logic             last_of_run;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

### rtl/core/stb_ram.sv
module stb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/software_timer_bank.sv
// start/stop: a single transfer, busy stays low, no results
// tick: busy for the whole walk, one decrementer walks the countdown memory
// one timer per cycle through its registered read port; next transfer once busy is low
// each expiry is held until the next one or the end of the walk, then strobed from a register;
// the last one comes in the first cycle with busy low
// synchronous active-low reset idles every timer at once through per-timer valid bits
`include "software_timer_bank_assert.svh"

module software_timer_bank #(
    parameter int NUM_TIMERS  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  stb_pkg::t_cmd   i_cmd,
    output logic            busy,
    output logic            o_strobe,
    output stb_pkg::t_result o_result
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int RW = COUNT_WIDTH + 1;

    stb_pkg::t_state           r_state, n_state;
    logic [NUM_TIMERS-1:0]     r_valid, n_valid;
    logic [CW-1:0]             r_rd_cnt, n_rd_cnt;
    logic                      r_s1_vld, n_s1_vld;
    logic [AW-1:0]             r_s1_idx, n_s1_idx;
    logic                      r_pend_vld, n_pend_vld;
    logic [stb_pkg::IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic                      r_strobe, n_strobe;
    stb_pkg::t_result          r_result, n_result;

    logic                   cnt_we;
    logic [AW-1:0]          cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [COUNT_WIDTH-1:0] cnt_rdata;
    logic                   rel_we;
    logic [AW-1:0]          rel_waddr;
    logic [RW-1:0]          rel_wdata;
    logic [RW-1:0]          rel_rdata;
    logic [AW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] dec_cnt;
    logic                   cmd_in_range;
    logic [AW-1:0]          cmd_addr;

    // countdown store, valid bit gates entries never started or since stopped
    stb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    // reload period and repeat flag, written on start only
    stb_ram #(.WIDTH(RW), .DEPTH(NUM_TIMERS)) u_rel_ram (
        .i_clk   (i_clk),
        .i_we    (rel_we),
        .i_waddr (rel_waddr),
        .i_wdata (rel_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rel_rdata)
    );

    assign rd_addr      = r_rd_cnt[AW-1:0];
    assign cur_cnt      = r_valid[r_s1_idx] ? cnt_rdata : '0;
    assign dec_cnt      = cur_cnt - COUNT_WIDTH'(1);
    assign cmd_in_range = (32'(i_cmd.timer_index) < NUM_TIMERS);
    assign cmd_addr     = AW'(i_cmd.timer_index);

    assign busy     = (r_state != stb_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stb_pkg::ST_IDLE;
            r_valid    <= '0;
            r_rd_cnt   <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_rd_cnt   <= n_rd_cnt;
            r_s1_vld   <= n_s1_vld;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_idx   <= n_s1_idx;
        r_pend_idx <= n_pend_idx;
        r_result   <= n_result;
    end

    // sequencer: command decode, countdown walk, expiry reporting
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_rd_cnt   = r_rd_cnt;
        n_s1_vld   = 1'b0;
        n_s1_idx   = r_s1_idx;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_strobe   = 1'b0;
        n_result   = r_result;
        cnt_we     = 1'b0;
        cnt_waddr  = cmd_addr;
        cnt_wdata  = COUNT_WIDTH'(i_cmd.period_ticks);
        rel_we     = 1'b0;
        rel_waddr  = cmd_addr;
        rel_wdata  = {i_cmd.periodic, COUNT_WIDTH'(i_cmd.period_ticks)};

        case (r_state)
            stb_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_cmd.opcode)
                        stb_pkg::OP_TICK: begin
                            n_state  = stb_pkg::ST_WALK;
                            n_rd_cnt = '0;
                        end
                        stb_pkg::OP_START: begin
                            if (cmd_in_range) begin
                                cnt_we            = 1'b1;
                                rel_we            = 1'b1;
                                n_valid[cmd_addr] = 1'b1;
                            end
                        end
                        stb_pkg::OP_STOP: begin
                            if (cmd_in_range) begin
                                n_valid[cmd_addr] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stb_pkg::ST_WALK: begin
                // issue the next read
                if (r_rd_cnt != CW'(NUM_TIMERS)) begin
                    n_rd_cnt = r_rd_cnt + CW'(1);
                    n_s1_vld = 1'b1;
                    n_s1_idx = r_rd_cnt[AW-1:0];
                end
                // decrement the timer whose data just came back
                if (r_s1_vld && (cur_cnt != '0)) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_s1_idx;
                    cnt_wdata = dec_cnt;
                    if (dec_cnt == '0) begin
                        if (rel_rdata[COUNT_WIDTH]) begin
                            cnt_wdata = rel_rdata[COUNT_WIDTH-1:0];
                        end
                        // release the held expiry, hold this one
                        if (r_pend_vld) begin
                            n_strobe = 1'b1;
                            n_result = '{expired_index: r_pend_idx, last_of_run: 1'b0};
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = stb_pkg::IDX_W'(r_s1_idx);
                    end
                end
                // walk done: flush the held expiry as the last one
                if (!r_s1_vld && (r_rd_cnt == CW'(NUM_TIMERS))) begin
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_result = '{expired_index: r_pend_idx, last_of_run: 1'b1};
                    end
                    n_pend_vld = 1'b0;
                    n_state    = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stb_pkg::ST_IDLE;
            end
        endcase
    end

    // checks
    `STB_ASSERT_IMPL(a_pend_only_walk, i_clk, i_rst_n, r_state == stb_pkg::ST_IDLE, !r_pend_vld)
    `STB_ASSERT_IMPL(a_s1_after_read, i_clk, i_rst_n, r_s1_vld, r_rd_cnt != '0)
    `STB_ASSERT_IMPL(a_strobe_from_walk, i_clk, i_rst_n, r_strobe, $past(r_state == stb_pkg::ST_WALK))
    `STB_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, start && !busy && i_cmd.opcode == stb_pkg::OP_TICK, busy)
    `STB_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, r_strobe && r_result.last_of_run, !r_strobe)

endmodule
